/* rtl/core/rational_arith_reduce_assert.svh */
// Assertion macros for the rational arithmetic controller.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rar assertion failed");

// Next-cycle implication, disabled during reset.
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rar assertion failed");

`endif

/* rtl/core/rar_pkg.sv */
// Shared constants, codes and command/status types for the rational arithmetic block.
package rar_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int NUM_W        = 2 * OPERAND_BITS;
    localparam int CNT_W        = $clog2(NUM_W + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;

    typedef enum logic [1:0] {
        MUL_T1,
        MUL_T2,
        MUL_DEN
    } t_mul_sel;

    typedef enum logic [1:0] {
        RES_ERR,
        RES_NOP,
        RES_CMP,
        RES_RED
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        t_mul_sel  mul_sel;
        logic      sum;
        logic      gcd_init;
        logic      gcd_step;
        logic      gcd_fin;
        logic      div_init_num;
        logic      div_init_den;
        logic      div_step;
        logic      store_num;
        logic      store_den;
        logic      res_set;
        t_res_kind res_kind;
    } t_cmd;

    typedef struct packed {
        logic       den_zero;
        logic       bn_zero;
        logic [2:0] op;
        logic       gcd_done;
    } t_sts;

endpackage

/* rtl/core/rational_arith_reduce.sv */
// Top level of the rational arithmetic block: controller plus datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_operation, i_a_num, i_a_den, i_b_num,
//          |           |                           | i_b_den
//  out     | output    | o_out_valid / i_out_stall | o_result_num, o_result_den, o_is_less,
//          |           |                           | o_is_equal, o_status
//
// One transaction at a time. Errors and unused codes go from the check state straight to the final
// state, compare runs two cross multiplies, add/sub run three multiplies, the sum, the binary GCD
// loop and two divisions, and mul/div skip the second multiply.
// The GCD loop and the one-bit-per-cycle divider, run once for the numerator and once
// for the denominator, dominate the run time. Reset is synchronous, active low, and clears
// only control state. A finished result sits in the output register while the core
// goes idle; a new result waits in the final state while the output stays stalled.
module rational_arith_reduce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_result_num,
    output logic [62:0]        o_result_den,
    output logic               o_is_less,
    output logic               o_is_equal,
    output logic [1:0]         o_status
);
    import rar_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing and handshakes
    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic and result registers
    rar_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_operation  (i_operation),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_sts        (w_sts),
        .o_result_num (o_result_num),
        .o_result_den (o_result_den),
        .o_is_less    (o_is_less),
        .o_is_equal   (o_is_equal),
        .o_status     (o_status)
    );

endmodule

/* rtl/core/rar_dp.sv */
// Datapath: operand capture, shared multiplier, binary GCD, restoring divider, result registers.
module rar_dp (
    input  logic                  i_clk,
    input  rar_pkg::t_cmd         i_cmd,
    input  logic [2:0]            i_operation,
    input  logic signed [31:0]    i_a_num,
    input  logic signed [31:0]    i_a_den,
    input  logic signed [31:0]    i_b_num,
    input  logic signed [31:0]    i_b_den,
    output rar_pkg::t_sts         o_sts,
    output logic signed [63:0]    o_result_num,
    output logic [62:0]           o_result_den,
    output logic                  o_is_less,
    output logic                  o_is_equal,
    output logic [1:0]            o_status
);
    import rar_pkg::*;

    localparam int OB = OPERAND_BITS;

    logic [2:0]       r_op;
    logic [OB-1:0]    r_an_mag, r_ad_mag, r_bn_mag, r_bd_mag;
    logic             r_an_neg, r_bn_neg;
    logic [NUM_W-1:0] r_t1_mag, r_t2_mag, r_num_mag, r_den;
    logic             r_t1_neg, r_t2_neg, r_num_neg;
    logic [NUM_W-1:0] r_x, r_y, r_g;
    logic [CNT_W-1:0] r_k;
    logic [NUM_W-1:0] r_rem, r_quo, r_num_q, r_den_q;
    logic signed [63:0] r_res_num;
    logic [62:0]      r_res_den;
    logic             r_less, r_eq;
    logic [1:0]       r_status;

    // operand sign/magnitude split
    logic [OB-1:0] w_an_v, w_ad_v, w_bn_v, w_bd_v;
    logic [OB-1:0] w_an_m, w_ad_m, w_bn_m, w_bd_m;
    logic          w_an_n, w_bn_n;

    assign w_an_v = i_a_num[OB-1:0];
    assign w_ad_v = i_a_den[OB-1:0];
    assign w_bn_v = i_b_num[OB-1:0];
    assign w_bd_v = i_b_den[OB-1:0];
    assign w_an_m = w_an_v[OB-1] ? (~w_an_v + 1'b1) : w_an_v;
    assign w_ad_m = w_ad_v[OB-1] ? (~w_ad_v + 1'b1) : w_ad_v;
    assign w_bn_m = w_bn_v[OB-1] ? (~w_bn_v + 1'b1) : w_bn_v;
    assign w_bd_m = w_bd_v[OB-1] ? (~w_bd_v + 1'b1) : w_bd_v;
    // denominator sign folds onto the numerator; zero stays positive
    assign w_an_n = (w_an_v[OB-1] ^ w_ad_v[OB-1]) && (w_an_m != '0);
    assign w_bn_n = (w_bn_v[OB-1] ^ w_bd_v[OB-1]) && (w_bn_m != '0);

    // shared multiplier
    logic [OB-1:0]    w_ma, w_mb;
    logic             w_mneg;
    logic [NUM_W-1:0] w_prod;

    always_comb begin
        w_ma   = r_ad_mag;
        w_mb   = r_bd_mag;
        w_mneg = 1'b0;
        unique case (i_cmd.mul_sel)
            MUL_T1: begin
                w_ma   = r_an_mag;
                w_mb   = (r_op == OP_MUL) ? r_bn_mag : r_bd_mag;
                w_mneg = (r_op == OP_MUL || r_op == OP_DIV) ? (r_an_neg ^ r_bn_neg)
                                                             : r_an_neg;
            end
            MUL_T2: begin
                w_ma   = r_bn_mag;
                w_mb   = r_ad_mag;
                w_mneg = r_bn_neg;
            end
            MUL_DEN: begin
                w_ma   = r_ad_mag;
                w_mb   = (r_op == OP_DIV) ? r_bn_mag : r_bd_mag;
                w_mneg = 1'b0;
            end
            default: begin
                w_ma   = r_ad_mag;
                w_mb   = r_bd_mag;
                w_mneg = 1'b0;
            end
        endcase
    end

    assign w_prod = NUM_W'(w_ma) * NUM_W'(w_mb);

    // signed add of the two cross products
    logic             w_t2n;
    logic [NUM_W-1:0] w_sum_mag;
    logic             w_sum_neg;

    always_comb begin
        w_t2n = (r_op == OP_SUB) ? (r_t2_neg ^ (r_t2_mag != '0)) : r_t2_neg;
        if (r_t1_neg == w_t2n) begin
            w_sum_mag = r_t1_mag + r_t2_mag;
            w_sum_neg = r_t1_neg;
        end else if (r_t1_mag >= r_t2_mag) begin
            w_sum_mag = r_t1_mag - r_t2_mag;
            w_sum_neg = r_t1_neg;
        end else begin
            w_sum_mag = r_t2_mag - r_t1_mag;
            w_sum_neg = w_t2n;
        end
        if (w_sum_mag == '0) begin
            w_sum_neg = 1'b0;
        end
    end

    // divider trial subtract
    logic [NUM_W:0] w_trial;
    logic           w_qbit;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_g});

    // compare and reduced-result checks
    logic signed [NUM_W:0] w_l, w_r;
    logic [64:0]           w_nq_ext, w_dq_ext;
    logic                  w_ovf;

    assign w_l      = r_t1_neg ? -$signed({1'b0, r_t1_mag}) : $signed({1'b0, r_t1_mag});
    assign w_r      = r_t2_neg ? -$signed({1'b0, r_t2_mag}) : $signed({1'b0, r_t2_mag});
    assign w_nq_ext = 65'(r_num_q);
    assign w_dq_ext = 65'(r_den_q);
    assign w_ovf    = (!r_num_neg && w_nq_ext > 65'h0_7FFF_FFFF_FFFF_FFFF)
                   || ( r_num_neg && w_nq_ext > 65'h0_8000_0000_0000_0000)
                   || (w_dq_ext > 65'h0_7FFF_FFFF_FFFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_an_mag <= w_an_m;
            r_ad_mag <= w_ad_m;
            r_bn_mag <= w_bn_m;
            r_bd_mag <= w_bd_m;
            r_an_neg <= w_an_n;
            r_bn_neg <= w_bn_n;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MUL_T1: begin
                    r_t1_mag <= w_prod;
                    r_t1_neg <= w_mneg && (w_prod != '0);
                end
                MUL_T2: begin
                    r_t2_mag <= w_prod;
                    r_t2_neg <= w_mneg && (w_prod != '0);
                end
                MUL_DEN: r_den <= w_prod;
                default: r_den <= w_prod;
            endcase
        end
        if (i_cmd.sum) begin
            if (r_op == OP_ADD || r_op == OP_SUB) begin
                r_num_mag <= w_sum_mag;
                r_num_neg <= w_sum_neg;
            end else begin
                r_num_mag <= r_t1_mag;
                r_num_neg <= r_t1_neg;
            end
        end
        // binary GCD, one step per cycle; y stays nonzero
        if (i_cmd.gcd_init) begin
            r_x <= r_num_mag;
            r_y <= r_den;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.gcd_fin) begin
            r_g <= r_y << r_k;
        end
        // restoring divider, one quotient bit per cycle
        if (i_cmd.div_init_num) begin
            r_rem <= '0;
            r_quo <= r_num_mag;
        end else if (i_cmd.div_init_den) begin
            r_rem <= '0;
            r_quo <= r_den;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? NUM_W'(w_trial - {1'b0, r_g}) : w_trial[NUM_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_qbit};
        end
        if (i_cmd.store_num) begin
            r_num_q <= r_quo;
        end
        if (i_cmd.store_den) begin
            r_den_q <= r_quo;
        end
        if (i_cmd.res_set) begin
            r_res_num <= '0;
            r_res_den <= 63'd1;
            r_less    <= 1'b0;
            r_eq      <= 1'b0;
            r_status  <= ST_OK;
            unique case (i_cmd.res_kind)
                RES_ERR: r_status <= ST_ZERO_DEN;
                RES_NOP: r_status <= ST_OK;
                RES_CMP: begin
                    r_less <= (w_l < w_r);
                    r_eq   <= (w_l == w_r);
                end
                RES_RED: begin
                    if (r_num_q == '0) begin
                        r_status <= ST_OK;
                    end else if (w_ovf) begin
                        r_status <= ST_OVF;
                    end else begin
                        r_res_num <= r_num_neg ? -$signed(w_nq_ext[63:0])
                                               : $signed(w_nq_ext[63:0]);
                        r_res_den <= w_dq_ext[62:0];
                    end
                end
                default: r_status <= ST_OK;
            endcase
        end
    end

    assign o_sts.den_zero = (r_ad_mag == '0) || (r_bd_mag == '0);
    assign o_sts.bn_zero  = (r_bn_mag == '0);
    assign o_sts.op       = r_op;
    assign o_sts.gcd_done = (r_x == '0);

    assign o_result_num = r_res_num;
    assign o_result_den = r_res_den;
    assign o_is_less    = r_less;
    assign o_is_equal   = r_eq;
    assign o_status     = r_status;

endmodule

/* rtl/core/rar_ctrl.sv */
// Controller: sequences multiply, GCD and divide steps and owns both handshakes.
module rar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rar_pkg::t_sts i_sts,
    output rar_pkg::t_cmd o_cmd
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_res_kind        r_kind, n_kind;
    logic             r_out_valid, n_out_valid;
    t_cmd             w_cmd;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && i_out_stall;
        w_cmd       = '0;
        w_cmd.mul_sel  = MUL_T1;
        w_cmd.res_kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.den_zero) begin
                    n_kind  = RES_ERR;
                    n_state = S_FIN;
                end else if (i_sts.op == OP_DIV && i_sts.bn_zero) begin
                    n_kind  = RES_ERR;
                    n_state = S_FIN;
                end else if (i_sts.op > OP_CMP) begin
                    n_kind  = RES_NOP;
                    n_state = S_FIN;
                end else begin
                    n_state = S_M1;
                end
            end
            S_M1: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_T1;
                n_state = (i_sts.op == OP_MUL || i_sts.op == OP_DIV) ? S_M3 : S_M2;
            end
            S_M2: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_T2;
                if (i_sts.op == OP_CMP) begin
                    n_kind  = RES_CMP;
                    n_state = S_FIN;
                end else begin
                    n_state = S_M3;
                end
            end
            S_M3: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_DEN;
                n_state       = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum = 1'b1;
                n_state   = S_GCD;
            end
            S_GCD: begin
                // first cycle here loads x/y; done flag then tracks the live x
                if (r_cnt == '0) begin
                    w_cmd.gcd_init = 1'b1;
                    n_cnt          = CNT_W'(1);
                end else if (i_sts.gcd_done) begin
                    w_cmd.gcd_fin      = 1'b1;
                    w_cmd.div_init_num = 1'b1;
                    n_cnt              = '0;
                    n_state            = S_DIVN;
                end else begin
                    w_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN: begin
                if (r_cnt == CNT_W'(NUM_W)) begin
                    w_cmd.store_num    = 1'b1;
                    w_cmd.div_init_den = 1'b1;
                    n_cnt              = '0;
                    n_state            = S_DIVD;
                end else begin
                    w_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end
            S_DIVD: begin
                if (r_cnt == CNT_W'(NUM_W)) begin
                    w_cmd.store_den = 1'b1;
                    n_cnt           = '0;
                    n_kind          = RES_RED;
                    n_state         = S_FIN;
                end else begin
                    w_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_kind = r_kind;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_kind      <= RES_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`include "rational_arith_reduce_assert.svh"

    `RAR_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_CHK)
    `RAR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.res_set, !(r_out_valid && i_out_stall))
    `RAR_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, r_state == S_DIVN || r_state == S_DIVD, r_cnt <= CNT_W'(NUM_W))
    `RAR_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, w_cmd.res_set, r_out_valid)

endmodule
